/* rtl/charger_safety_monitor_core_defines.svh */
// assertion helpers used by the monitor core
`ifndef CHARGER_SAFETY_MONITOR_CORE_DEFINES_SVH
`define CHARGER_SAFETY_MONITOR_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("csm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("csm assertion failed");

`endif

/* rtl/csm_pkg.sv */
package csm_pkg;

	// monitor constants
	localparam logic [15:0] ADC_FULL_SCALE     = 16'd65535;
	localparam logic [10:0] TICK_MS            = 11'd10;
	localparam logic [15:0] CAPACITY_UNLIMITED = 16'd65535;

	localparam logic [10:0] MS_PER_SEC          = 11'd1000;
	localparam logic [5:0]  SEC_PER_MIN_LAST    = 6'd59;
	localparam logic [15:0] TIME_UNLIMITED_FROM = 16'd1000;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_CHECK     = 2'd1,
		OP_POWER_ON  = 2'd2,
		OP_POWER_OFF = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_RUNNING  = 2'd0,
		ST_ERROR    = 2'd1,
		ST_COMPLETE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		RSN_NONE         = 4'd0,
		RSN_INT_TEMP     = 4'd1,
		RSN_DISCONNECTED = 4'd2,
		RSN_BALANCE_PORT = 4'd3,
		RSN_CURRENT      = 4'd4,
		RSN_VIN          = 4'd5,
		RSN_CAPACITY     = 4'd6,
		RSN_TIME         = 4'd7,
		RSN_EXT_TEMP     = 4'd8
	} reason_t;

	typedef enum logic [2:0] {
		CFG_INTERNAL_TEMP_LIMIT  = 3'd0,
		CFG_VOUT_MIN_ADC         = 3'd1,
		CFG_CURRENT_LIMIT        = 3'd2,
		CFG_INPUT_VOLTAGE_LOW    = 3'd3,
		CFG_CAPACITY_LIMIT       = 3'd4,
		CFG_TIME_LIMIT_MIN       = 3'd5,
		CFG_EXTERNAL_TEMP_ENABLE = 3'd6,
		CFG_EXTERNAL_TEMP_CUTOFF = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		op_t         operation;
		logic [15:0] t_internal;
		logic [15:0] vout_adc;
		logic        balance_connected;
		logic [15:0] output_current;
		logic [15:0] input_voltage;
		logic [15:0] capacity;
		logic [15:0] t_external;
		logic        converter_active;
		logic        discharger_powered;
		logic        balancer_active;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		reason_t     stop_reason;
		logic [15:0] charge_time_sec;
		logic [15:0] balance_time_sec;
	} res_t;

endpackage

/* rtl/csm_stream_if.sv */
interface csm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/charger_safety_monitor_core.sv */
// charger safety monitor core
// channels: cmd (sink, csm_pkg::cmd_t) takes one operation per transaction:
//   slow tick, check, power on or power off; res (source, csm_pkg::res_t)
//   returns exactly one result per cmd transaction, in order
// config: cfg_wr_en/cfg_index/cfg_data write one threshold register per
//   clock; the user sees that writes are made only while no transaction is in flight; the block does not check this
// pipeline: a cmd transaction is registered in stage 1 and evaluated there
//   against the monitor state; its result is loaded into stage 2 when stage
//   1 advances, and res.valid is driven from stage 2
// throughput: one transaction per cycle unless res stalls; the state update
//   (accumulators, running flag) is a single compare-and-subtract step per cycle
// millisecond accumulators carry their seconds (and, for charge, minutes)
//   alongside, so no divider is needed; a 32-bit wrap restarts all derived counts
// reset: arst_n clears valids, monitor state, accumulators and loads the
//   threshold registers with their defaults
// stall: when res is not taken, stage 2 holds and stage 1 holds behind
//   it; cmd.ready drops only when both stages are full
`include "charger_safety_monitor_core_defines.svh"

module charger_safety_monitor_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  csm_pkg::cfg_idx_t cfg_index,
	input  logic [15:0]       cfg_data,
	csm_stream_if.sink        cmd,
	csm_stream_if.source      res
);
	import csm_pkg::*;

	// threshold registers
	logic [15:0] int_temp_limit_q;
	logic [15:0] vout_min_adc_q;
	logic [15:0] current_limit_q;
	logic [15:0] vin_low_q;
	logic [15:0] capacity_limit_q;
	logic [15:0] time_limit_min_q;
	logic        ext_temp_en_q;
	logic [15:0] ext_temp_cutoff_q;

	// monitor state
	logic        monitor_on_q;
	logic        bal_ref_q;
	// charge accumulator with derived seconds/minutes
	logic [31:0] chg_ms_q;
	logic [9:0]  chg_rem_q;      // ms within the current second
	logic [15:0] chg_sec_q;      // low bits of whole seconds
	logic [5:0]  chg_sec_in_min_q;
	logic [16:0] chg_min_q;      // whole minutes, full range
	// balance accumulator with derived seconds
	logic [31:0] bal_ms_q;
	logic [9:0]  bal_rem_q;
	logic [15:0] bal_sec_q;

	// pipeline
	logic valid_s1;
	cmd_t cmd_s1;
	logic valid_s2;
	res_t res_s2;
	logic adv;

	// next state
	logic        monitor_on_d;
	logic        bal_ref_d;
	logic [31:0] chg_ms_d;
	logic [9:0]  chg_rem_d;
	logic [15:0] chg_sec_d;
	logic [5:0]  chg_sec_in_min_d;
	logic [16:0] chg_min_d;
	logic [31:0] bal_ms_d;
	logic [9:0]  bal_rem_d;
	logic [15:0] bal_sec_d;
	status_t     status_d;
	reason_t     reason_d;

	// stage 1 moves on whenever the result register is free or being taken
	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || adv;

	assign res.valid   = valid_s2;
	assign res.payload = res_s2;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_temp_limit_q  <= 16'd6000;
			vout_min_adc_q    <= 16'd0;
			current_limit_q   <= 16'd65535;
			vin_low_q         <= 16'd0;
			capacity_limit_q  <= 16'd65535;
			time_limit_min_q  <= 16'd1000;
			ext_temp_en_q     <= 1'b0;
			ext_temp_cutoff_q <= 16'd65535;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_INTERNAL_TEMP_LIMIT:  int_temp_limit_q  <= cfg_data;
				CFG_VOUT_MIN_ADC:         vout_min_adc_q    <= cfg_data;
				CFG_CURRENT_LIMIT:        current_limit_q   <= cfg_data;
				CFG_INPUT_VOLTAGE_LOW:    vin_low_q         <= cfg_data;
				CFG_CAPACITY_LIMIT:       capacity_limit_q  <= cfg_data;
				CFG_TIME_LIMIT_MIN:       time_limit_min_q  <= cfg_data;
				CFG_EXTERNAL_TEMP_ENABLE: ext_temp_en_q     <= cfg_data[0];
				CFG_EXTERNAL_TEMP_CUTOFF: ext_temp_cutoff_q <= cfg_data;
				default:                  ext_temp_en_q     <= ext_temp_en_q;
			endcase
		end
	end

	// stage 1: operation decode, accumulator update and stop checks
	always_comb begin
		logic [32:0] chg_sum;
		logic [32:0] bal_sum;
		logic [10:0] chg_rem_sum;
		logic [10:0] bal_rem_sum;

		monitor_on_d     = monitor_on_q;
		bal_ref_d        = bal_ref_q;
		chg_ms_d         = chg_ms_q;
		chg_rem_d        = chg_rem_q;
		chg_sec_d        = chg_sec_q;
		chg_sec_in_min_d = chg_sec_in_min_q;
		chg_min_d        = chg_min_q;
		bal_ms_d         = bal_ms_q;
		bal_rem_d        = bal_rem_q;
		bal_sec_d        = bal_sec_q;
		status_d         = ST_RUNNING;
		reason_d         = RSN_NONE;

		chg_sum     = {1'b0, chg_ms_q} + {22'd0, TICK_MS};
		bal_sum     = {1'b0, bal_ms_q} + {22'd0, TICK_MS};
		chg_rem_sum = {1'b0, chg_rem_q} + TICK_MS;
		bal_rem_sum = {1'b0, bal_rem_q} + TICK_MS;

		unique case (cmd_s1.operation)
			OP_TICK: begin
				if (cmd_s1.converter_active) begin
					chg_ms_d = chg_sum[31:0];
					if (chg_sum[32]) begin
						// wrapped past 2^32: remaining ms is below one second
						chg_rem_d        = chg_sum[9:0];
						chg_sec_d        = 16'd0;
						chg_sec_in_min_d = 6'd0;
						chg_min_d        = 17'd0;
					end else if (chg_rem_sum >= MS_PER_SEC) begin
						chg_rem_d = 10'(chg_rem_sum - MS_PER_SEC);
						chg_sec_d = chg_sec_q + 16'd1;
						if (chg_sec_in_min_q == SEC_PER_MIN_LAST) begin
							chg_sec_in_min_d = 6'd0;
							chg_min_d        = chg_min_q + 17'd1;
						end else begin
							chg_sec_in_min_d = chg_sec_in_min_q + 6'd1;
						end
					end else begin
						chg_rem_d = chg_rem_sum[9:0];
					end
				end
				if (cmd_s1.balancer_active) begin
					bal_ms_d = bal_sum[31:0];
					if (bal_sum[32]) begin
						bal_rem_d = bal_sum[9:0];
						bal_sec_d = 16'd0;
					end else if (bal_rem_sum >= MS_PER_SEC) begin
						bal_rem_d = 10'(bal_rem_sum - MS_PER_SEC);
						bal_sec_d = bal_sec_q + 16'd1;
					end else begin
						bal_rem_d = bal_rem_sum[9:0];
					end
				end
			end
			OP_CHECK: begin
				if (monitor_on_q) begin
					priority if (cmd_s1.t_internal > int_temp_limit_q) begin
						status_d = ST_ERROR;
						reason_d = RSN_INT_TEMP;
					end else if (cmd_s1.vout_adc >= ADC_FULL_SCALE ||
							(cmd_s1.vout_adc < vout_min_adc_q &&
							cmd_s1.discharger_powered)) begin
						status_d = ST_ERROR;
						reason_d = RSN_DISCONNECTED;
					end else if (cmd_s1.balance_connected != bal_ref_q) begin
						status_d = ST_ERROR;
						reason_d = RSN_BALANCE_PORT;
					end else if (cmd_s1.output_current > current_limit_q) begin
						status_d = ST_ERROR;
						reason_d = RSN_CURRENT;
					end else if (cmd_s1.input_voltage < vin_low_q) begin
						status_d = ST_ERROR;
						reason_d = RSN_VIN;
					end else if (capacity_limit_q != CAPACITY_UNLIMITED &&
							cmd_s1.capacity > capacity_limit_q) begin
						status_d = ST_COMPLETE;
						reason_d = RSN_CAPACITY;
					end else if (time_limit_min_q < TIME_UNLIMITED_FROM &&
							{1'b0, time_limit_min_q} <= chg_min_q) begin
						status_d = ST_COMPLETE;
						reason_d = RSN_TIME;
					end else if (ext_temp_en_q &&
							cmd_s1.t_external > ext_temp_cutoff_q) begin
						status_d = ST_ERROR;
						reason_d = RSN_EXT_TEMP;
					end else begin
						status_d = ST_RUNNING;
						reason_d = RSN_NONE;
					end
				end
			end
			OP_POWER_ON: begin
				chg_ms_d         = 32'd0;
				chg_rem_d        = 10'd0;
				chg_sec_d        = 16'd0;
				chg_sec_in_min_d = 6'd0;
				chg_min_d        = 17'd0;
				bal_ms_d         = 32'd0;
				bal_rem_d        = 10'd0;
				bal_sec_d        = 16'd0;
				bal_ref_d        = cmd_s1.balance_connected;
				monitor_on_d     = 1'b1;
			end
			OP_POWER_OFF: begin
				monitor_on_d = 1'b0;
			end
			default: begin
				monitor_on_d = monitor_on_q;
			end
		endcase
	end

	// monitor state, committed as each transaction leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			monitor_on_q     <= 1'b0;
			bal_ref_q        <= 1'b0;
			chg_ms_q         <= 32'd0;
			chg_rem_q        <= 10'd0;
			chg_sec_q        <= 16'd0;
			chg_sec_in_min_q <= 6'd0;
			chg_min_q        <= 17'd0;
			bal_ms_q         <= 32'd0;
			bal_rem_q        <= 10'd0;
			bal_sec_q        <= 16'd0;
		end else if (adv) begin
			monitor_on_q     <= monitor_on_d;
			bal_ref_q        <= bal_ref_d;
			chg_ms_q         <= chg_ms_d;
			chg_rem_q        <= chg_rem_d;
			chg_sec_q        <= chg_sec_d;
			chg_sec_in_min_q <= chg_sec_in_min_d;
			chg_min_q        <= chg_min_d;
			bal_ms_q         <= bal_ms_d;
			bal_rem_q        <= bal_rem_d;
			bal_sec_q        <= bal_sec_d;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (!valid_s2 || res.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.payload;
		end
		if (adv) begin
			res_s2.status           <= status_d;
			res_s2.stop_reason      <= reason_d;
			res_s2.charge_time_sec  <= chg_sec_d;
			res_s2.balance_time_sec <= bal_sec_d;
		end
	end

	// a pending result is never overwritten while stalled
	`CSM_ASSERT_IMPL(a_no_overwrite, clk, arst_n, valid_s2 && !res.ready && valid_s1, !adv)
	// the sub-second remainders stay within one second
	`CSM_ASSERT_IMPL(a_rem_range, clk, arst_n, 1'b1,
		chg_rem_q < MS_PER_SEC[9:0] && bal_rem_q < MS_PER_SEC[9:0])
	// seconds-within-minute never reaches a full minute
	`CSM_ASSERT_IMPL(a_sec_in_min_range, clk, arst_n, 1'b1,
		chg_sec_in_min_q <= SEC_PER_MIN_LAST)
	// a stop reason is given exactly when the status is not running
	`CSM_ASSERT_IMPL(a_reason_status, clk, arst_n, valid_s2,
		(res_s2.status == ST_RUNNING) == (res_s2.stop_reason == RSN_NONE))
	// power on starts a running session with cleared times
	`CSM_ASSERT_NEXT(a_power_on, clk, arst_n, adv && cmd_s1.operation == OP_POWER_ON,
		monitor_on_q && chg_ms_q == 32'd0 && bal_ms_q == 32'd0 && chg_min_q == 17'd0)

endmodule
